### src/bgt_pkg.sv
package bgt_pkg;

	// Default depth of the source byte store
	localparam int SOURCE_BYTES_DEF = 65536;

	// Field widths
	localparam int BYTE_W     = 8;
	localparam int COORD_W    = 9;
	localparam int ADDR_IN_W  = 16;
	localparam int LIN_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hff;

	// Source pixel layouts
	typedef enum logic [1:0] {
		MODE_GRAY    = 2'd0,
		MODE_MONO    = 2'd1,
		MODE_LCD_RGB = 2'd2,
		MODE_LCD_BGR = 2'd3
	} source_mode_t;

	// Texture formats
	localparam logic FMT_ALPHA = 1'b0;
	localparam logic FMT_RGBA  = 1'b1;

	// Item functions
	localparam logic FUNC_STORE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_MODE    = 3'd0,
		REG_TEXTURE_FORMAT = 3'd1,
		REG_PADDING_WIDTH  = 3'd2,
		REG_SOURCE_WIDTH   = 3'd3,
		REG_SOURCE_ROWS    = 3'd4,
		REG_ROW_PITCH      = 3'd5
	} reg_index_t;

	// Control of the single store port
	typedef struct packed {
		logic en;
		logic we;
	} store_req_t;

	// Divide an 8-bit value by three through a reciprocal multiply
	function automatic logic [BYTE_W-1:0] div3(input logic [BYTE_W-1:0] v);
		logic [15:0] p;
		p = 16'(v) * 16'd171;
		return 8'(p[15:9]);
	endfunction

endpackage

### src/bgt_store.sv
module bgt_store #(
	parameter int DEPTH = bgt_pkg::SOURCE_BYTES_DEF
) (
	input  logic                           clk,
	input  bgt_pkg::store_req_t            req,
	input  logic [$clog2(DEPTH)-1:0]       addr,
	input  logic [bgt_pkg::BYTE_W-1:0]     wdata,
	output logic [bgt_pkg::BYTE_W-1:0]     rdata
);

	logic [bgt_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [bgt_pkg::BYTE_W-1:0] rdata_q;

	// Single port: write, or read with registered data
	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

### src/bgt_wrap.sv
module bgt_wrap #(
	parameter int SOURCE_BYTES = bgt_pkg::SOURCE_BYTES_DEF
) (
	input  logic                              clk,
	input  logic [bgt_pkg::LIN_W-1:0]         lin,
	output logic [$clog2(SOURCE_BYTES)-1:0]   addr
);

	localparam int AW    = $clog2(SOURCE_BYTES);
	localparam int Q_W   = bgt_pkg::LIN_W - AW + 1;
	localparam int P_W   = bgt_pkg::LIN_W + 33;
	localparam logic [32:0] RECIP = 33'((64'd1 << 32) / SOURCE_BYTES);

	logic [P_W-1:0]               prod;
	logic [bgt_pkg::LIN_W-1:0]    lin_s1;
	logic [Q_W-1:0]               q_s1;
	logic [bgt_pkg::LIN_W:0]      rem;
	logic [AW-1:0]                addr_s2;

	// Estimate the quotient; it is exact or one short
	assign prod = P_W'(lin) * P_W'(RECIP);

	always_ff @(posedge clk) begin
		lin_s1 <= lin;
		q_s1   <= Q_W'(prod >> 32);
	end

	// Remainder lies below twice the depth: correct once
	assign rem = (bgt_pkg::LIN_W + 1)'(32'(lin_s1) - 32'(q_s1) * 32'(SOURCE_BYTES));

	always_ff @(posedge clk) begin
		if (32'(rem) >= SOURCE_BYTES) begin
			addr_s2 <= AW'(32'(rem) - SOURCE_BYTES);
		end else begin
			addr_s2 <= AW'(rem);
		end
	end

	assign addr = addr_s2;

endmodule

### src/glyph_bitmap_to_texture_unit.sv
// Channel   Signals                                          Transaction
// in        in_valid/in_ready, func, byte_address,          one store or texel read
//           byte_value, texel_x, texel_y
// out       out_valid/out_ready, red, green, blue, alpha,   one result per input item
//           texture_width, texture_height, texel_inside
// cfg       cfg_write, cfg_index, cfg_data                   one register write
//
// One item at a time. A store passes through ST_WRITE and ST_DONE, a read outside
// the bitmap through ST_CALC and ST_DONE. A gray or mono texel reads one source byte,
// an lcd texel three, each by a read of the single-port store and a capture, after a
// multiply and a two-stage address wrap. A result waits in an output register while
// the next item is taken; a held result stalls only the finish of the following item.
// arst_n clears control and configuration; the source store is not cleared.
module glyph_bitmap_to_texture_unit #(
	parameter int SOURCE_BYTES = bgt_pkg::SOURCE_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic [bgt_pkg::ADDR_IN_W-1:0]       byte_address,
	input  logic [bgt_pkg::BYTE_W-1:0]          byte_value,
	input  logic [bgt_pkg::COORD_W-1:0]         texel_x,
	input  logic [bgt_pkg::COORD_W-1:0]         texel_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bgt_pkg::BYTE_W-1:0]          red,
	output logic [bgt_pkg::BYTE_W-1:0]          green,
	output logic [bgt_pkg::BYTE_W-1:0]          blue,
	output logic [bgt_pkg::BYTE_W-1:0]          alpha,
	output logic [bgt_pkg::COORD_W-1:0]         texture_width,
	output logic [bgt_pkg::COORD_W-1:0]         texture_height,
	output logic                                texel_inside,
	input  logic                                cfg_write,
	input  logic [bgt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bgt_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AW = $clog2(SOURCE_BYTES);
	localparam int BW = bgt_pkg::BYTE_W;
	localparam int CW = bgt_pkg::COORD_W;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_WRITE = 8'b0000_0010,
		ST_CALC  = 8'b0000_0100,
		ST_QUOT  = 8'b0000_1000,
		ST_ADDR  = 8'b0001_0000,
		ST_RD    = 8'b0010_0000,
		ST_CAP   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t st_q;

	// Configuration registers
	bgt_pkg::source_mode_t mode_q;
	logic                  fmt_q;
	logic [3:0]            pad_q;
	logic [BW-1:0]         sw_q;
	logic [BW-1:0]         rows_q;
	logic [BW-1:0]         pitch_q;

	// Item registers
	logic                           func_q;
	logic [bgt_pkg::ADDR_IN_W-1:0]  baddr_q;
	logic [BW-1:0]                  bval_q;
	logic [CW-1:0]                  tx_q;
	logic [CW-1:0]                  ty_q;

	// Read sequencing
	logic [bgt_pkg::LIN_W-1:0] lin_q;
	logic [1:0]                k_q;
	logic [1:0]                last_k;
	logic [AW-1:0]             nxt_q;
	logic [AW-1:0]             rd_a;
	logic [AW:0]               rd_inc;
	logic [AW-1:0]             addr_w;
	logic [BW-1:0]             byte_q [3];

	// Store port
	bgt_pkg::store_req_t store_req;
	logic [AW-1:0]       store_addr;
	logic [BW-1:0]       rdata;
	logic                wr_in_range;

	// Geometry
	logic [BW-1:0]             iw;
	logic                      exists;
	logic [CW-1:0]             tw;
	logic [CW-1:0]             th;
	logic                      in_bounds;
	logic                      interior;
	logic [BW-1:0]             col;
	logic [BW-1:0]             row;
	logic [bgt_pkg::LIN_W-1:0] offset;

	// Result
	logic          hit;
	logic [BW-1:0] r_d, g_d, b_d, a_d;
	logic [BW-1:0] cov;
	logic          out_valid_q;
	logic          out_load;
	logic [BW-1:0] red_q, green_q, blue_q, alpha_q;
	logic [CW-1:0] tw_q, th_q;
	logic          inside_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= bgt_pkg::MODE_GRAY;
			fmt_q   <= bgt_pkg::FMT_ALPHA;
			pad_q   <= '0;
			sw_q    <= '0;
			rows_q  <= '0;
			pitch_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				bgt_pkg::REG_SOURCE_MODE:    mode_q  <= bgt_pkg::source_mode_t'(cfg_data[1:0]);
				bgt_pkg::REG_TEXTURE_FORMAT: fmt_q   <= cfg_data[0];
				bgt_pkg::REG_PADDING_WIDTH:  pad_q   <= cfg_data[3:0];
				bgt_pkg::REG_SOURCE_WIDTH:   sw_q    <= cfg_data;
				bgt_pkg::REG_SOURCE_ROWS:    rows_q  <= cfg_data;
				bgt_pkg::REG_ROW_PITCH:      pitch_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Texture size and coordinate classification
	always_comb begin
		iw        = mode_q[1] ? bgt_pkg::div3(sw_q) : sw_q;
		exists    = (sw_q != '0) && (rows_q != '0) && !(mode_q[1] && (fmt_q == bgt_pkg::FMT_ALPHA));
		tw        = exists ? CW'(iw) + CW'({pad_q, 1'b0}) : '0;
		th        = exists ? CW'(rows_q) + CW'({pad_q, 1'b0}) : '0;
		in_bounds = (tx_q < tw) && (ty_q < th);
		interior  = (tx_q >= CW'(pad_q)) && (tx_q < CW'(pad_q) + CW'(iw)) &&
			(ty_q >= CW'(pad_q)) && (ty_q < CW'(pad_q) + CW'(rows_q));
		col       = BW'(tx_q - CW'(pad_q));
		row       = BW'(ty_q - CW'(pad_q));
		case (mode_q)
			bgt_pkg::MODE_GRAY: offset = bgt_pkg::LIN_W'(col);
			bgt_pkg::MODE_MONO: offset = bgt_pkg::LIN_W'(col >> 3);
			default:            offset = bgt_pkg::LIN_W'(col) + bgt_pkg::LIN_W'({col, 1'b0});
		endcase
		last_k = mode_q[1] ? 2'd2 : 2'd0;
	end

	// Address wrap unit
	bgt_wrap #(
		.SOURCE_BYTES(SOURCE_BYTES)
	) u_wrap (
		.clk (clk),
		.lin (lin_q),
		.addr(addr_w)
	);

	// Byte address of the current fetch and of the next one
	assign rd_a   = (k_q == 2'd0) ? addr_w : nxt_q;
	assign rd_inc = (AW + 1)'(rd_a) + (AW + 1)'(1);

	// Store port control
	assign wr_in_range = (32'(baddr_q) < SOURCE_BYTES);
	always_comb begin
		store_req.en = 1'b0;
		store_req.we = 1'b0;
		store_addr   = rd_a;
		if (st_q == ST_WRITE) begin
			store_req.en = wr_in_range;
			store_req.we = 1'b1;
			store_addr   = AW'(baddr_q);
		end else if (st_q == ST_RD) begin
			store_req.en = 1'b1;
		end
	end

	bgt_store #(
		.DEPTH(SOURCE_BYTES)
	) u_store (
		.clk  (clk),
		.req  (store_req),
		.addr (store_addr),
		.wdata(bval_q),
		.rdata(rdata)
	);

	assign in_ready = (st_q == ST_IDLE);
	assign out_load = (st_q == ST_DONE) && (!out_valid_q || out_ready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			k_q  <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						st_q <= (func == bgt_pkg::FUNC_READ) ? ST_CALC : ST_WRITE;
					end
				end
				ST_WRITE: st_q <= ST_DONE;
				ST_CALC: begin
					k_q  <= '0;
					st_q <= (in_bounds && interior) ? ST_QUOT : ST_DONE;
				end
				ST_QUOT: st_q <= ST_ADDR;
				ST_ADDR: st_q <= ST_RD;
				ST_RD:   st_q <= ST_CAP;
				ST_CAP: begin
					if (k_q == last_k) begin
						st_q <= ST_DONE;
					end else begin
						k_q  <= k_q + 2'd1;
						st_q <= ST_RD;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the item, the linear address, and the fetched bytes
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q  <= func;
			baddr_q <= byte_address;
			bval_q  <= byte_value;
			tx_q    <= texel_x;
			ty_q    <= texel_y;
		end
		if (st_q == ST_CALC) begin
			lin_q <= bgt_pkg::LIN_W'(bgt_pkg::LIN_W'(row) * bgt_pkg::LIN_W'(pitch_q) + offset);
		end
		if (st_q == ST_RD) begin
			nxt_q <= (32'(rd_inc) == SOURCE_BYTES) ? '0 : AW'(rd_inc);
		end
		if (st_q == ST_CAP) begin
			byte_q[k_q] <= rdata;
		end
	end

	// Assemble the texel
	always_comb begin
		hit = (func_q == bgt_pkg::FUNC_READ) && in_bounds && interior;
		cov = (mode_q == bgt_pkg::MODE_MONO) ?
			(byte_q[0][~col[2:0]] ? bgt_pkg::FULL_BYTE : '0) : byte_q[0];
		r_d = '0;
		g_d = '0;
		b_d = '0;
		a_d = '0;
		if (hit) begin
			case (mode_q)
				bgt_pkg::MODE_LCD_RGB: begin
					r_d = byte_q[0];
					g_d = byte_q[1];
					b_d = byte_q[2];
					a_d = bgt_pkg::FULL_BYTE;
				end
				bgt_pkg::MODE_LCD_BGR: begin
					r_d = byte_q[2];
					g_d = byte_q[1];
					b_d = byte_q[0];
					a_d = bgt_pkg::FULL_BYTE;
				end
				default: begin
					a_d = cov;
					if (fmt_q == bgt_pkg::FMT_RGBA) begin
						r_d = bgt_pkg::FULL_BYTE;
						g_d = bgt_pkg::FULL_BYTE;
						b_d = bgt_pkg::FULL_BYTE;
					end
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			red_q    <= r_d;
			green_q  <= g_d;
			blue_q   <= b_d;
			alpha_q  <= a_d;
			tw_q     <= tw;
			th_q     <= th;
			inside_q <= (func_q == bgt_pkg::FUNC_READ) && in_bounds;
		end
	end

	assign out_valid      = out_valid_q;
	assign red            = red_q;
	assign green          = green_q;
	assign blue           = blue_q;
	assign alpha          = alpha_q;
	assign texture_width  = tw_q;
	assign texture_height = th_q;
	assign texel_inside   = inside_q;

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(store_req.en && store_req.we) |-> (wr_in_range && (func_q == bgt_pkg::FUNC_STORE)))
		else $error("store write outside the store or for a read transaction");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transaction taken while one is in flight");

	a_lcd_rgba: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RD && mode_q[1]) |-> (fmt_q == bgt_pkg::FMT_RGBA))
		else $error("lcd fetch for an alpha-only texture");

	a_store_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && func_q == bgt_pkg::FUNC_STORE) |=>
		(out_valid && alpha == '0 && red == '0 && !texel_inside))
		else $error("store transaction produced a texel");

	a_fetch_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CAP) |-> (k_q <= last_k))
		else $error("fetch count beyond the bytes of one texel");

endmodule

### test/glyph_bitmap_to_texture_unit_tb.sv
`timescale 1ns / 100ps

module glyph_bitmap_to_texture_unit_tb;

	localparam int CLK_PERIOD      = 20;
	localparam int RESET_CYCLES    = 9;
	localparam int STORE_DEPTH     = bgt_pkg::SOURCE_BYTES_DEF;
	localparam int PHASES          = 18;
	localparam int ITEMS_PER_PHASE = 105;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int DRAIN_CYCLES    = 24;

	// Indexes past the last register; writes to them must be dropped
	localparam logic [bgt_pkg::CFG_IDX_W-1:0] REG_SPARE       = 3'd6;
	localparam logic [bgt_pkg::CFG_IDX_W-1:0] REG_BEYOND_LAST = 3'd7;

	typedef struct packed {
		logic                          func;
		logic [bgt_pkg::ADDR_IN_W-1:0] addr;
		logic [bgt_pkg::BYTE_W-1:0]    value;
		logic [bgt_pkg::COORD_W-1:0]   tx;
		logic [bgt_pkg::COORD_W-1:0]   ty;
	} glyph_req_t;

	typedef struct packed {
		logic [bgt_pkg::BYTE_W-1:0]  red;
		logic [bgt_pkg::BYTE_W-1:0]  green;
		logic [bgt_pkg::BYTE_W-1:0]  blue;
		logic [bgt_pkg::BYTE_W-1:0]  alpha;
		logic [bgt_pkg::COORD_W-1:0] tex_w;
		logic [bgt_pkg::COORD_W-1:0] tex_h;
		logic                        in_tex;
	} texel_result_t;

	typedef enum logic {
		ROW_WRITE,
		ROW_ITEM
	} row_kind_t;

	typedef struct {
		row_kind_t                     kind;
		logic [bgt_pkg::CFG_IDX_W-1:0] reg_idx;
		logic [bgt_pkg::BYTE_W-1:0]    reg_val;
		glyph_req_t                    req;
		bit                            typed;
		texel_result_t                 want;
	} plan_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid;
	logic                           in_ready;
	logic                           func;
	logic [bgt_pkg::ADDR_IN_W-1:0]  byte_address;
	logic [bgt_pkg::BYTE_W-1:0]     byte_value;
	logic [bgt_pkg::COORD_W-1:0]    texel_x;
	logic [bgt_pkg::COORD_W-1:0]    texel_y;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [bgt_pkg::BYTE_W-1:0]     red;
	logic [bgt_pkg::BYTE_W-1:0]     green;
	logic [bgt_pkg::BYTE_W-1:0]     blue;
	logic [bgt_pkg::BYTE_W-1:0]     alpha;
	logic [bgt_pkg::COORD_W-1:0]    texture_width;
	logic [bgt_pkg::COORD_W-1:0]    texture_height;
	logic                           texel_inside;
	logic                           cfg_write;
	logic [bgt_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bgt_pkg::CFG_DATA_W-1:0] cfg_data;

	// Mirror of the block's registers and source store
	bgt_pkg::source_mode_t      cur_mode;
	logic                       cur_format;
	logic [3:0]                 cur_pad;
	logic [bgt_pkg::BYTE_W-1:0] cur_width;
	logic [bgt_pkg::BYTE_W-1:0] cur_rows;
	logic [bgt_pkg::BYTE_W-1:0] cur_pitch;
	logic [bgt_pkg::BYTE_W-1:0] glyph_bytes [0:STORE_DEPTH-1];
	bit                         byte_written [0:STORE_DEPTH-1];

	texel_result_t expected_texels[$];
	plan_row_t     plan[$];
	int            mismatches = 0;
	int unsigned   items_sent = 0;
	int unsigned   send_idle_pct = 13;
	int unsigned   recv_idle_pct = 55;
	bit            hold_armed = 1'b0;

	glyph_bitmap_to_texture_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.byte_address   (byte_address),
		.byte_value     (byte_value),
		.texel_x        (texel_x),
		.texel_y        (texel_y),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.alpha          (alpha),
		.texture_width  (texture_width),
		.texture_height (texture_height),
		.texel_inside   (texel_inside),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Padded texture size and interior column count; zero size when nothing to show
	function automatic void texture_size(output int unsigned w, output int unsigned h,
			output int unsigned cols);
		bit lcd;
		lcd = cur_mode[1];
		cols = lcd ? int'(cur_width) / 3 : int'(cur_width);
		w = 0;
		h = 0;
		if (cur_width != 0 && cur_rows != 0 && !(lcd && cur_format == bgt_pkg::FMT_ALPHA)) begin
			w = cols + 2 * int'(cur_pad);
			h = int'(cur_rows) + 2 * int'(cur_pad);
		end
	endfunction

	// Source bytes behind an interior texel read; empty for anything else
	function automatic void source_addrs(input glyph_req_t req, output int unsigned addrs[$]);
		int unsigned w, h, cols, pad, col, row, base;
		addrs.delete();
		texture_size(w, h, cols);
		pad = cur_pad;
		if (req.func != bgt_pkg::FUNC_READ || w == 0)
			return;
		if (req.tx < pad || req.tx >= pad + cols || req.ty < pad || req.ty >= pad + cur_rows)
			return;
		col  = req.tx - pad;
		row  = req.ty - pad;
		base = row * cur_pitch;
		case (cur_mode)
			bgt_pkg::MODE_GRAY: addrs.push_back((base + col) % STORE_DEPTH);
			bgt_pkg::MODE_MONO: addrs.push_back((base + col / 8) % STORE_DEPTH);
			default: begin
				for (int k = 0; k < 3; k++)
					addrs.push_back((base + col * 3 + k) % STORE_DEPTH);
			end
		endcase
	endfunction

	// Work out the result of one transaction and apply its store
	function automatic texel_result_t predict_texel(input glyph_req_t req);
		texel_result_t res;
		int unsigned   w, h, cols, col;
		int unsigned   at[$];
		logic [7:0]    b;
		res = '0;
		texture_size(w, h, cols);
		res.tex_w = bgt_pkg::COORD_W'(w);
		res.tex_h = bgt_pkg::COORD_W'(h);
		if (req.func == bgt_pkg::FUNC_STORE) begin
			glyph_bytes[req.addr]  = req.value;
			byte_written[req.addr] = 1'b1;
		end else if (req.tx < w && req.ty < h) begin
			res.in_tex = 1'b1;
			source_addrs(req, at);
			if (at.size() != 0) begin
				case (cur_mode)
					bgt_pkg::MODE_GRAY, bgt_pkg::MODE_MONO: begin
						if (cur_mode == bgt_pkg::MODE_GRAY) begin
							res.alpha = glyph_bytes[at[0]];
						end else begin
							b   = glyph_bytes[at[0]];
							col = req.tx - cur_pad;
							res.alpha = b[7 - col % 8] ? bgt_pkg::FULL_BYTE : 8'h00;
						end
						if (cur_format == bgt_pkg::FMT_RGBA) begin
							res.red   = bgt_pkg::FULL_BYTE;
							res.green = bgt_pkg::FULL_BYTE;
							res.blue  = bgt_pkg::FULL_BYTE;
						end
					end
					bgt_pkg::MODE_LCD_RGB: begin
						res.red   = glyph_bytes[at[0]];
						res.green = glyph_bytes[at[1]];
						res.blue  = glyph_bytes[at[2]];
						res.alpha = bgt_pkg::FULL_BYTE;
					end
					default: begin
						res.red   = glyph_bytes[at[2]];
						res.green = glyph_bytes[at[1]];
						res.blue  = glyph_bytes[at[0]];
						res.alpha = bgt_pkg::FULL_BYTE;
					end
				endcase
			end
		end
		return res;
	endfunction

	function automatic glyph_req_t store_req(input int unsigned addr, input int unsigned value);
		glyph_req_t req;
		req.func  = bgt_pkg::FUNC_STORE;
		req.addr  = bgt_pkg::ADDR_IN_W'(addr);
		req.value = bgt_pkg::BYTE_W'(value);
		req.tx    = bgt_pkg::COORD_W'($urandom_range(511));
		req.ty    = bgt_pkg::COORD_W'($urandom_range(511));
		return req;
	endfunction

	function automatic glyph_req_t read_req(input int unsigned x, input int unsigned y);
		glyph_req_t req;
		req.func  = bgt_pkg::FUNC_READ;
		req.addr  = bgt_pkg::ADDR_IN_W'($urandom_range(65535));
		req.value = bgt_pkg::BYTE_W'($urandom_range(255));
		req.tx    = bgt_pkg::COORD_W'(x);
		req.ty    = bgt_pkg::COORD_W'(y);
		return req;
	endfunction

	function automatic texel_result_t texel(input int r, input int g, input int b, input int a,
			input int w, input int h, input int in_tex);
		texel_result_t t;
		t.red    = bgt_pkg::BYTE_W'(r);
		t.green  = bgt_pkg::BYTE_W'(g);
		t.blue   = bgt_pkg::BYTE_W'(b);
		t.alpha  = bgt_pkg::BYTE_W'(a);
		t.tex_w  = bgt_pkg::COORD_W'(w);
		t.tex_h  = bgt_pkg::COORD_W'(h);
		t.in_tex = in_tex[0];
		return t;
	endfunction

	function automatic void add_write(input logic [bgt_pkg::CFG_IDX_W-1:0] idx,
			input int unsigned val);
		plan_row_t row;
		row.kind    = ROW_WRITE;
		row.reg_idx = idx;
		row.reg_val = bgt_pkg::BYTE_W'(val);
		row.req     = '0;
		row.typed   = 1'b0;
		row.want    = '0;
		plan.push_back(row);
	endfunction

	function automatic void add_item(input glyph_req_t req, input bit typed,
			input texel_result_t want);
		plan_row_t row;
		row.kind    = ROW_ITEM;
		row.reg_idx = bgt_pkg::REG_SOURCE_MODE;
		row.reg_val = '0;
		row.req     = req;
		row.typed   = typed;
		row.want    = want;
		plan.push_back(row);
	endfunction

	// Directed table: empty bitmap, gray, mono, unsupported lcd, narrow lcd, rgb/bgr, extremes
	function automatic void build_plan();
		// empty bitmap after reset
		add_item(read_req(0, 0), 1, texel(0, 0, 0, 0, 0, 0, 0));
		add_item(store_req(0, 8'h80), 1, texel(0, 0, 0, 0, 0, 0, 0));
		// 2x2 gray with a one-texel border, RGBA
		add_write(bgt_pkg::REG_SOURCE_MODE, bgt_pkg::MODE_GRAY);
		add_write(bgt_pkg::REG_TEXTURE_FORMAT, bgt_pkg::FMT_RGBA);
		add_write(bgt_pkg::REG_PADDING_WIDTH, 1);
		add_write(bgt_pkg::REG_SOURCE_WIDTH, 2);
		add_write(bgt_pkg::REG_SOURCE_ROWS, 2);
		add_write(bgt_pkg::REG_ROW_PITCH, 2);
		add_item(store_req(1, 8'hff), 1, texel(0, 0, 0, 0, 4, 4, 0));
		add_item(store_req(2, 8'h00), 1, texel(0, 0, 0, 0, 4, 4, 0));
		add_item(store_req(3, 8'h5a), 0, '0);
		add_item(read_req(0, 0), 1, texel(0, 0, 0, 0, 4, 4, 1));
		add_item(read_req(1, 1), 1, texel(8'hff, 8'hff, 8'hff, 8'h80, 4, 4, 1));
		add_item(read_req(2, 1), 1, texel(8'hff, 8'hff, 8'hff, 8'hff, 4, 4, 1));
		add_item(read_req(4, 1), 1, texel(0, 0, 0, 0, 4, 4, 0));
		add_item(read_req(511, 511), 1, texel(0, 0, 0, 0, 4, 4, 0));
		// alpha-only format
		add_write(bgt_pkg::REG_TEXTURE_FORMAT, bgt_pkg::FMT_ALPHA);
		add_item(read_req(2, 1), 1, texel(0, 0, 0, 8'hff, 4, 4, 1));
		add_item(read_req(2, 2), 0, '0);
		// mono, MSB first; the stray index write must change nothing
		add_write(bgt_pkg::REG_SOURCE_MODE, bgt_pkg::MODE_MONO);
		add_write(bgt_pkg::REG_SOURCE_WIDTH, 8);
		add_write(bgt_pkg::REG_SOURCE_ROWS, 1);
		add_write(bgt_pkg::REG_PADDING_WIDTH, 0);
		add_write(bgt_pkg::REG_ROW_PITCH, 1);
		add_write(REG_BEYOND_LAST, 8'hff);
		add_item(read_req(0, 0), 1, texel(0, 0, 0, 8'hff, 8, 1, 1));
		add_item(read_req(7, 0), 1, texel(0, 0, 0, 0, 8, 1, 1));
		// lcd into alpha format is unsupported
		add_write(bgt_pkg::REG_SOURCE_MODE, bgt_pkg::MODE_LCD_RGB);
		add_item(read_req(0, 0), 1, texel(0, 0, 0, 0, 0, 0, 0));
		// lcd row shorter than one triple: border only
		add_write(bgt_pkg::REG_TEXTURE_FORMAT, bgt_pkg::FMT_RGBA);
		add_write(bgt_pkg::REG_SOURCE_WIDTH, 2);
		add_write(bgt_pkg::REG_PADDING_WIDTH, 2);
		add_item(read_req(0, 0), 1, texel(0, 0, 0, 0, 4, 5, 1));
		add_item(read_req(2, 2), 1, texel(0, 0, 0, 0, 4, 5, 1));
		// two-texel lcd row: the first texel read as rgb, the second as bgr
		add_write(bgt_pkg::REG_SOURCE_WIDTH, 6);
		add_write(bgt_pkg::REG_PADDING_WIDTH, 0);
		add_write(bgt_pkg::REG_ROW_PITCH, 6);
		add_item(store_req(4, 8'h11), 1, texel(0, 0, 0, 0, 2, 1, 0));
		add_item(store_req(5, 8'h22), 0, '0);
		add_item(read_req(0, 0), 1, texel(8'h80, 8'hff, 8'h00, 8'hff, 2, 1, 1));
		add_write(bgt_pkg::REG_SOURCE_MODE, bgt_pkg::MODE_LCD_BGR);
		add_item(read_req(1, 0), 1, texel(8'h22, 8'h11, 8'h5a, 8'hff, 2, 1, 1));
		add_item(store_req(16'hffff, 8'ha5), 1, texel(0, 0, 0, 0, 2, 1, 0));
		// largest texture
		add_write(bgt_pkg::REG_SOURCE_MODE, bgt_pkg::MODE_GRAY);
		add_write(bgt_pkg::REG_PADDING_WIDTH, 15);
		add_write(bgt_pkg::REG_SOURCE_WIDTH, 255);
		add_write(bgt_pkg::REG_SOURCE_ROWS, 255);
		add_write(bgt_pkg::REG_ROW_PITCH, 255);
		add_item(read_req(0, 0), 1, texel(0, 0, 0, 0, 285, 285, 1));
		add_item(read_req(284, 284), 1, texel(0, 0, 0, 0, 285, 285, 1));
		add_item(read_req(285, 0), 1, texel(0, 0, 0, 0, 285, 285, 0));
		add_item(read_req(15, 15), 1, texel(8'hff, 8'hff, 8'hff, 8'h80, 285, 285, 1));
	endfunction

	// Write one register once all results are back; called on a falling edge
	task automatic write_reg(input logic [bgt_pkg::CFG_IDX_W-1:0] idx,
			input logic [bgt_pkg::BYTE_W-1:0] val);
		in_valid = 1'b0;
		while (expected_texels.size() != 0)
			@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_write = 1'b0;
		case (idx)
			bgt_pkg::REG_SOURCE_MODE:    cur_mode   = bgt_pkg::source_mode_t'(val[1:0]);
			bgt_pkg::REG_TEXTURE_FORMAT: cur_format = val[0];
			bgt_pkg::REG_PADDING_WIDTH:  cur_pad    = val[3:0];
			bgt_pkg::REG_SOURCE_WIDTH:   cur_width  = val;
			bgt_pkg::REG_SOURCE_ROWS:    cur_rows   = val;
			bgt_pkg::REG_ROW_PITCH:      cur_pitch  = val;
			default: ;
		endcase
	endtask

	// Offer one transaction and queue its expected result; called on a falling edge
	task automatic push_item(input glyph_req_t req, input bit typed,
			input texel_result_t want);
		texel_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid     = 1'b1;
		func         = req.func;
		byte_address = req.addr;
		byte_value   = req.value;
		texel_x      = req.tx;
		texel_y      = req.ty;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		res = predict_texel(req);
		expected_texels.push_back(typed ? want : res);
		items_sent++;
		@(negedge clk);
	endtask

	// Fill any source byte a read would touch that has never been written
	task automatic cover_source(input glyph_req_t req);
		int unsigned at[$];
		source_addrs(req, at);
		foreach (at[i]) begin
			if (!byte_written[at[i]])
				push_item(store_req(at[i], $urandom_range(255)), 0, '0);
		end
	endtask

	// Pick a fresh bitmap layout; upper data bits of narrow registers carry junk
	task automatic load_random_config(input bit extreme);
		int unsigned mode, fmt, pad, width, rows, pitch, row_bytes;
		mode = $urandom_range(3);
		fmt  = (mode >= 2 && $urandom_range(99) < 80) ? 1 : $urandom_range(1);
		if (extreme) begin
			pad   = $urandom_range(1) ? 15 : 0;
			width = 255;
			rows  = $urandom_range(1) ? 255 : 1;
			pitch = $urandom_range(1) ? 255 : 0;
		end else begin
			pad   = ($urandom_range(99) < 80) ? $urandom_range(3) : $urandom_range(15);
			width = $urandom_range(mode >= 2 ? 30 : 24);
			rows  = $urandom_range(10);
			row_bytes = (mode == bgt_pkg::MODE_MONO) ? (width + 7) / 8 : width;
			pitch = ($urandom_range(99) < 75) ? row_bytes + $urandom_range(4) :
				$urandom_range(255);
		end
		write_reg(bgt_pkg::REG_SOURCE_MODE, {6'($urandom), mode[1:0]});
		write_reg(bgt_pkg::REG_TEXTURE_FORMAT, {7'($urandom), fmt[0]});
		write_reg(bgt_pkg::REG_PADDING_WIDTH, {4'($urandom), pad[3:0]});
		write_reg(bgt_pkg::REG_SOURCE_WIDTH, width[7:0]);
		write_reg(bgt_pkg::REG_SOURCE_ROWS, rows[7:0]);
		write_reg(bgt_pkg::REG_ROW_PITCH, pitch[7:0]);
		if ($urandom_range(3) == 0)
			write_reg($urandom_range(1) ? REG_SPARE : REG_BEYOND_LAST, 8'($urandom));
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Drive out_ready; one long hold-off once armed, then the regime's stall rate
	always @(negedge clk) begin : receiver
		static int unsigned hold_left = 0;
		static bit hold_used = 1'b0;
		if (hold_armed && !hold_used) begin
			hold_left = HOLD_OFF_CYCLES;
			hold_used = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		texel_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_texels.size() == 0) begin
				$error("unexpected result transaction");
				mismatches++;
			end else begin
				want = expected_texels.pop_front();
				check_field("red", want.red, red);
				check_field("green", want.green, green);
				check_field("blue", want.blue, blue);
				check_field("alpha", want.alpha, alpha);
				check_field("texture_width", want.tex_w, texture_width);
				check_field("texture_height", want.tex_h, texture_height);
				check_field("texel_inside", want.in_tex, texel_inside);
			end
		end
	end

	// Abort when no transaction moves on either channel for too long
	initial begin : watchdog
		int unsigned stalled;
		stalled = 0;
		while (stalled < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("glyph_bitmap_to_texture_unit verification failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned   phase_start, w, h, cols, region;
		glyph_req_t    req;
		in_valid     = 1'b0;
		func         = bgt_pkg::FUNC_STORE;
		byte_address = '0;
		byte_value   = '0;
		texel_x      = '0;
		texel_y      = '0;
		cfg_write    = 1'b0;
		cfg_index    = bgt_pkg::REG_SOURCE_MODE;
		cfg_data     = '0;
		cur_mode     = bgt_pkg::MODE_GRAY;
		cur_format   = bgt_pkg::FMT_ALPHA;
		cur_pad      = '0;
		cur_width    = '0;
		cur_rows     = '0;
		cur_pitch    = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table
		build_plan();
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE)
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			else
				push_item(plan[i].req, plan[i].typed, plan[i].want);
		end

		// Random phases: sender light/receiver heavy, swapped, then no idling
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase / 6)
				0: begin
					send_idle_pct = 13;
					recv_idle_pct = 55;
				end
				1: begin
					send_idle_pct = 55;
					recv_idle_pct = 13;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			load_random_config(phase % 6 == 5);
			if (phase == 2)
				hold_armed = 1'b1;
			phase_start = items_sent;
			while (items_sent - phase_start < ITEMS_PER_PHASE) begin
				texture_size(w, h, cols);
				if ($urandom_range(99) < 20) begin
					region = cur_rows * cur_pitch + cur_width;
					if (region > 65535 || $urandom_range(1) == 0)
						region = 65535;
					push_item(store_req($urandom_range(region), $urandom_range(255)), 0, '0);
				end else begin
					req = read_req(
						($urandom_range(99) < 15) ? $urandom_range(511) : $urandom_range(w + 1),
						($urandom_range(99) < 15) ? $urandom_range(511) : $urandom_range(h + 1));
					cover_source(req);
					push_item(req, 0, '0);
				end
			end
		end

		// Drain
		in_valid = 1'b0;
		while (expected_texels.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("glyph_bitmap_to_texture_unit verification clean");
		else
			$display("glyph_bitmap_to_texture_unit verification failed");
		$finish;
	end

endmodule
